### src/stp_pkg.sv
// Shared types, constants and rate tables for the stepper axis step controller.
package stp_pkg;

	// Default width of the position counter and the limits.
	localparam int POS_WIDTH_DEFAULT = 16;

	// Divider operand widths: the prescaled clock needs 25 bits and a divisor
	// of up to 65536 needs 17.
	localparam int KW = 25;
	localparam int DW = 17;

	// Rate table size and the index width that covers it.
	localparam int RATE_STEPS = 20;
	localparam int IDX_W      = 5;

	// Reset values of the go-to rate and the timing it selects.
	localparam logic [15:0] MOVE_SPEED_RESET = 16'd1000;
	localparam logic [15:0] TOP_RESET        = 16'd19999;
	localparam logic [15:0] MID_RESET        = 16'd10000;
	localparam logic [6:0]  PRESCALE_RESET   = 7'd1;

	// Command codes.
	localparam logic [3:0] ACT_TICK       = 4'd0;
	localparam logic [3:0] ACT_GO_TO      = 4'd1;
	localparam logic [3:0] ACT_JOG        = 4'd2;
	localparam logic [3:0] ACT_STOP       = 4'd3;
	localparam logic [3:0] ACT_ZERO       = 4'd4;
	localparam logic [3:0] ACT_SET_UPPER  = 4'd5;
	localparam logic [3:0] ACT_SET_LOWER  = 4'd6;
	localparam logic [3:0] ACT_UPPER_HERE = 4'd7;
	localparam logic [3:0] ACT_LOWER_HERE = 4'd8;

	// Go-to answer codes.
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_BEYOND_LOWER = 2'd1;
	localparam logic [1:0] ST_BEYOND_UPPER = 2'd2;

	// One command item.
	typedef struct packed {
		logic [3:0]         action;
		logic signed [15:0] value;
		logic               stop_request;
	} cmd_item_t;

	// One result item.
	typedef struct packed {
		logic               step_out;
		logic               direction_out;
		logic               drive_enabled;
		logic               soft_estop;
		logic signed [15:0] position_out;
		logic [1:0]         status;
		logic [15:0]        actual_speed;
	} rsp_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic apply;
		logic hold;
		logic div_start;
		logic div_second;
		logic take_top;
		logic take_speed;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_status_t;

	// Highest step rate that still selects the next slower prescale.
	function automatic logic [15:0] rate_floor(input logic [IDX_W-1:0] j);
		case (j)
			5'd0:    return 16'd305;
			5'd1:    return 16'd152;
			5'd2:    return 16'd101;
			5'd3:    return 16'd76;
			5'd4:    return 16'd61;
			5'd5:    return 16'd50;
			5'd6:    return 16'd43;
			5'd7:    return 16'd38;
			5'd8:    return 16'd30;
			5'd9:    return 16'd25;
			5'd10:   return 16'd21;
			5'd11:   return 16'd19;
			5'd12:   return 16'd15;
			5'd13:   return 16'd12;
			5'd14:   return 16'd10;
			5'd15:   return 16'd9;
			5'd16:   return 16'd7;
			5'd17:   return 16'd6;
			5'd18:   return 16'd5;
			default: return 16'd0;
		endcase
	endfunction

	// Prescaled clock rate in Hz for each prescale step.
	function automatic logic [KW-1:0] clock_k(input logic [IDX_W-1:0] idx);
		case (idx)
			5'd0:    return 25'd20000000;
			5'd1:    return 25'd10000000;
			5'd2:    return 25'd6666666;
			5'd3:    return 25'd5000000;
			5'd4:    return 25'd4000000;
			5'd5:    return 25'd3333333;
			5'd6:    return 25'd2857143;
			5'd7:    return 25'd2500000;
			5'd8:    return 25'd2000000;
			5'd9:    return 25'd1666667;
			5'd10:   return 25'd1428571;
			5'd11:   return 25'd1250000;
			5'd12:   return 25'd1000000;
			5'd13:   return 25'd833333;
			5'd14:   return 25'd714286;
			5'd15:   return 25'd625000;
			5'd16:   return 25'd500000;
			5'd17:   return 25'd416667;
			5'd18:   return 25'd357143;
			default: return 25'd312500;
		endcase
	endfunction

	// Clock prescale for each prescale step.
	function automatic logic [6:0] div_of(input logic [IDX_W-1:0] idx);
		case (idx)
			5'd0:    return 7'd1;
			5'd1:    return 7'd2;
			5'd2:    return 7'd3;
			5'd3:    return 7'd4;
			5'd4:    return 7'd5;
			5'd5:    return 7'd6;
			5'd6:    return 7'd7;
			5'd7:    return 7'd8;
			5'd8:    return 7'd10;
			5'd9:    return 7'd12;
			5'd10:   return 7'd14;
			5'd11:   return 7'd16;
			5'd12:   return 7'd20;
			5'd13:   return 7'd24;
			5'd14:   return 7'd28;
			5'd15:   return 7'd32;
			5'd16:   return 7'd40;
			5'd17:   return 7'd48;
			5'd18:   return 7'd56;
			default: return 7'd64;
		endcase
	endfunction

	// The floors fall monotonically, so the last floor at or above the rate
	// gives the prescale step.
	function automatic logic [IDX_W-1:0] rate_index(input logic [15:0] f);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int j = 0; j < RATE_STEPS - 1; j++) begin
			if (f <= rate_floor(IDX_W'(j))) idx = IDX_W'(j + 1);
		end
		return idx;
	endfunction

endpackage

### src/stp_div.sv
// Restoring divider that resolves one quotient bit per cycle.
module stp_div
	import stp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [KW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [KW-1:0] quotient
);

	localparam int CW = $clog2(KW + 1);

	logic [KW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic [DW:0]   trial;
	logic          fits;

	// One trial subtraction of the shifted remainder.
	assign shifted = {rem_q, quo_q[KW-1]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign fits    = (shifted >= {1'b0, dsr_q});

	// Iteration counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(KW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Quotient and remainder shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[KW-2:0], fits};
			rem_q <= fits ? trial[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### src/stp_dp.sv
// Axis datapath: position, limits, step timer, timing setup and result forming.
module stp_dp
	import stp_pkg::*;
#(
	parameter int POSITION_WIDTH = POS_WIDTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	input  logic       cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  cmd_item_t  item,
	output rsp_item_t  result
);

	localparam int P = POSITION_WIDTH;
	localparam logic signed [P-1:0] POS_MAX = {1'b0, {(P - 1){1'b1}}};
	localparam logic signed [P-1:0] POS_MIN = {1'b1, {(P - 1){1'b0}}};

	// Axis state.
	logic [15:0]         move_speed_q;
	logic signed [P-1:0] pos_q, lower_q, upper_q, tgt_q;
	logic                down_q, run_q, estop_q, step_q;
	logic [6:0]          presc_q, pscnt_q;
	logic [15:0]         top_q, mid_q, pcnt_q, speed_q;

	// Move being set up while the divider works.
	logic                pend_down_q;
	logic signed [P-1:0] pend_tgt_q;
	logic [15:0]         pend_f_q;
	logic [IDX_W-1:0]    pend_idx_q;
	logic [15:0]         pend_top_q;
	logic [15:0]         pend_speed_q;

	// Next state.
	logic signed [P-1:0] n_pos, n_lower, n_upper, n_tgt;
	logic                n_down, n_run, n_estop, n_step;
	logic [6:0]          n_presc, n_pscnt;
	logic [15:0]         n_top, n_mid, n_pcnt, n_speed;
	logic [1:0]          n_status;

	logic signed [P-1:0] v;
	logic [15:0]         jog_f;
	logic                in_range;
	logic                pend_down_d;
	logic signed [P-1:0] pend_tgt_d;
	logic [15:0]         pend_f_d;
	logic [6:0]          ps_inc;
	logic [15:0]         pcnt_inc;
	logic signed [P-1:0] pos_step;
	logic                beyond;
	logic                arrived;
	logic                there;
	logic                div_done;
	logic [KW-1:0]       quotient;
	logic [KW-1:0]       quo_m1;
	logic [DW-1:0]       divisor;
	logic [16:0]         top_p1;

	// Command value decode.
	assign v        = P'(item.value);
	assign jog_f    = item.value[15] ? 16'(-item.value) : 16'(item.value);
	assign in_range = (v < lower_q) && (upper_q < v);

	assign status.need_div = ((item.action == ACT_GO_TO) && in_range) ||
	                         ((item.action == ACT_JOG) && (item.value != '0));
	assign status.div_done = div_done;

	// Direction, target and rate of a move that needs the divider.
	always_comb begin
		if (item.action == ACT_GO_TO) begin
			pend_down_d = (pos_q < v);
			pend_tgt_d  = v;
			pend_f_d    = move_speed_q;
		end else begin
			pend_down_d = !item.value[15];
			pend_tgt_d  = item.value[15] ? upper_q : lower_q;
			pend_f_d    = jog_f;
		end
	end

	// Timer and step arithmetic.
	assign ps_inc   = pscnt_q + 7'd1;
	assign pcnt_inc = (pcnt_q >= top_q) ? 16'd0 : pcnt_q + 16'd1;
	assign pos_step = down_q ? pos_q + P'(1) : pos_q - P'(1);
	assign beyond   = (lower_q < pos_q) || (pos_q < upper_q);
	assign arrived  = down_q ? !(pos_step < tgt_q) : !(tgt_q < pos_step);
	assign there    = pend_down_q ? !(pos_q < pend_tgt_q) : !(pend_tgt_q < pos_q);

	// Divider: first the period, then the achieved rate.
	assign top_p1  = {1'b0, pend_top_q} + 17'd1;
	assign divisor = cmd.div_second ? top_p1 : {1'b0, pend_f_q};
	assign quo_m1  = quotient - KW'(1);

	stp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (clock_k(pend_idx_q)),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Next axis state for the item at hand or for a finished move setup.
	always_comb begin
		n_pos    = pos_q;
		n_lower  = lower_q;
		n_upper  = upper_q;
		n_tgt    = tgt_q;
		n_down   = down_q;
		n_run    = run_q;
		n_estop  = estop_q;
		n_step   = step_q;
		n_presc  = presc_q;
		n_pscnt  = pscnt_q;
		n_top    = top_q;
		n_mid    = mid_q;
		n_pcnt   = pcnt_q;
		n_speed  = speed_q;
		n_status = ST_OK;
		if (cmd.commit) begin
			n_down  = pend_down_q;
			n_tgt   = pend_tgt_q;
			n_pscnt = '0;
			n_pcnt  = '0;
			n_step  = 1'b0;
			n_presc = div_of(pend_idx_q);
			n_top   = pend_top_q;
			n_mid   = top_p1[16:1];
			n_run   = !there;
			n_speed = there ? 16'd0 : pend_speed_q;
		end else begin
			case (item.action)
				ACT_TICK: begin
					if (run_q) begin
						if (ps_inc < presc_q) begin
							n_pscnt = ps_inc;
						end else begin
							n_pscnt = '0;
							n_pcnt  = pcnt_inc;
							// Mid-period: limit check, stop request, then the step.
							if (pcnt_inc == mid_q) begin
								if (beyond) begin
									n_estop = 1'b1;
									n_run   = 1'b0;
									n_speed = '0;
								end else if (item.stop_request) begin
									n_run   = 1'b0;
									n_speed = '0;
								end else begin
									n_step = 1'b1;
									n_pos  = pos_step;
									if (arrived) begin
										n_run   = 1'b0;
										n_speed = '0;
									end
								end
							end
							// Period end drops the step line.
							if (n_run && (pcnt_inc == top_q)) n_step = 1'b0;
						end
					end
				end
				ACT_GO_TO: begin
					if (!in_range) n_status = (v < lower_q) ? ST_BEYOND_UPPER : ST_BEYOND_LOWER;
				end
				ACT_JOG: begin
					if (item.value == '0) begin
						n_run   = 1'b0;
						n_speed = '0;
					end
				end
				ACT_STOP: begin
					n_run   = 1'b0;
					n_speed = '0;
				end
				ACT_ZERO:       n_pos   = '0;
				ACT_SET_UPPER:  n_upper = v;
				ACT_SET_LOWER:  n_lower = v;
				ACT_UPPER_HERE: n_upper = pos_q;
				ACT_LOWER_HERE: n_lower = pos_q;
				default: ;
			endcase
		end
	end

	// Result item from the updated state.
	assign result.step_out      = n_step;
	assign result.direction_out = n_down;
	assign result.drive_enabled = n_run;
	assign result.soft_estop    = n_estop;
	assign result.position_out  = 16'(n_pos);
	assign result.status        = n_status;
	assign result.actual_speed  = n_speed;

	// Axis state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_speed_q <= MOVE_SPEED_RESET;
			pos_q        <= '0;
			lower_q      <= POS_MAX;
			upper_q      <= POS_MIN;
			tgt_q        <= '0;
			down_q       <= 1'b0;
			run_q        <= 1'b0;
			estop_q      <= 1'b0;
			step_q       <= 1'b0;
			presc_q      <= PRESCALE_RESET;
			pscnt_q      <= '0;
			top_q        <= TOP_RESET;
			mid_q        <= MID_RESET;
			pcnt_q       <= '0;
			speed_q      <= '0;
		end else begin
			if (cfg_wen) move_speed_q <= cfg_wdata;
			if (cmd.apply || cmd.commit) begin
				pos_q   <= n_pos;
				lower_q <= n_lower;
				upper_q <= n_upper;
				tgt_q   <= n_tgt;
				down_q  <= n_down;
				run_q   <= n_run;
				estop_q <= n_estop;
				step_q  <= n_step;
				presc_q <= n_presc;
				pscnt_q <= n_pscnt;
				top_q   <= n_top;
				mid_q   <= n_mid;
				pcnt_q  <= n_pcnt;
				speed_q <= n_speed;
			end
		end
	end

	// Move setup registers, with the period and rate saturated to 16 bits.
	always_ff @(posedge clk) begin
		if (cmd.hold) begin
			pend_down_q <= pend_down_d;
			pend_tgt_q  <= pend_tgt_d;
			pend_f_q    <= pend_f_d;
			pend_idx_q  <= rate_index(pend_f_d);
		end
		if (cmd.take_top) begin
			pend_top_q <= (quo_m1 > KW'(16'hFFFF)) ? 16'hFFFF : quo_m1[15:0];
		end
		if (cmd.take_speed) begin
			pend_speed_q <= (quotient > KW'(16'hFFFF)) ? 16'hFFFF : quotient[15:0];
		end
	end

endmodule

### src/stp_ctrl.sv
// Controller: command acceptance and sequencing of the move setup divisions.
module stp_ctrl
	import stp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic       q_full,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       cmd_stall
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD_TOP,
		S_WAIT_TOP,
		S_LOAD_SPD,
		S_WAIT_SPD,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   accept;

	// A command transfers only when idle and the result queue has room.
	assign cmd_stall = (state_q != S_IDLE) || q_full;
	assign accept    = cmd_valid && !cmd_stall;

	// Datapath commands.
	always_comb begin
		cmd            = '0;
		cmd.apply      = accept && !status.need_div;
		cmd.hold       = accept && status.need_div;
		cmd.div_start  = (state_q == S_LOAD_TOP) || (state_q == S_LOAD_SPD);
		cmd.div_second = (state_q == S_LOAD_SPD);
		cmd.take_top   = (state_q == S_WAIT_TOP) && status.div_done;
		cmd.take_speed = (state_q == S_WAIT_SPD) && status.div_done;
		cmd.commit     = (state_q == S_COMMIT) && !q_full;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && status.need_div) state_q <= S_LOAD_TOP;
				end
				S_LOAD_TOP: begin
					state_q <= S_WAIT_TOP;
				end
				S_WAIT_TOP: begin
					if (status.div_done) state_q <= S_LOAD_SPD;
				end
				S_LOAD_SPD: begin
					state_q <= S_WAIT_SPD;
				end
				S_WAIT_SPD: begin
					if (status.div_done) state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (!q_full) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### src/stp_outq.sv
// Two-entry result queue between the datapath and the result channel.
module stp_outq
	import stp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rsp_item_t push_data,
	output logic      full,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp_data
);

	rsp_item_t  ent_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign rsp_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign pop       = rsp_valid && !rsp_stall;
	assign rsp_data  = ent_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_data;
	end

endmodule

### src/stepper_axis_step_controller.sv
// Top level of the single-axis stepper step controller.
//
// Commands transfer on the cmd channel (cmd_valid, cmd_stall, cmd_data) and
// each one yields exactly one result item on the rsp channel (rsp_valid,
// rsp_stall, rsp_data), in order. A tick command advances the step timer by
// one base clock; the others change the target, limits or position at once.
// Ticks and all other commands except accepted go-to and nonzero jog need no
// division: the result is valid the cycle after the transfer and a new command
// is taken every cycle while the result queue has room. A move start computes
// its period and achieved rate on one shared restoring divider, twice in turn,
// and cmd_stall stays high meanwhile.
// Results pass through a two-entry queue, so a command still transfers while
// one result waits; once the queue holds two, cmd_stall rises until the
// receiver takes one. Nothing is lost or repeated under stalls.
// move_speed is written through cfg_wen/cfg_wdata and applies to the next
// go-to. Reset clears the position and the motion, opens the limits fully,
// sets move_speed to 1000 and empties the result queue.
module stepper_axis_step_controller
	import stp_pkg::*;
#(
	parameter int POSITION_WIDTH = POS_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_item_t   cmd_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_item_t   rsp_data
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;
	rsp_item_t  result;
	logic       q_full;
	logic       push;

	// Every applied command or finished move setup produces one result.
	assign push = dp_cmd.apply || dp_cmd.commit;

	stp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.q_full    (q_full),
		.status    (dp_status),
		.cmd       (dp_cmd),
		.cmd_stall (cmd_stall)
	);

	stp_dp #(
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.status    (dp_status),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.item      (cmd_data),
		.result    (result)
	);

	stp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.full      (q_full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	// The queue is never written while it is full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("result queue written while full");

	// A running axis always reports a nonzero achieved rate, a halted one zero.
	a_speed_matches_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.drive_enabled == (rsp_data.actual_speed != 16'd0)))
		else $error("achieved rate disagrees with drive enable");

	// Once a transferred result shows the e-stop, later results keep it.
	a_estop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_stall && rsp_data.soft_estop) |=>
		(!rsp_valid || rsp_data.soft_estop))
		else $error("soft e-stop cleared without reset");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the stepper axis step controller: random and directed commands.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import stp_pkg::*;

	localparam int unsigned RUN_LIMIT    = 1000000;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned NUM_PHASES   = 8;

	// Command codes that the block ignores.
	localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
	localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	cmd_item_t   cmd_data  = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_item_t   rsp_data;

	stepper_axis_step_controller #(
		.POSITION_WIDTH(16)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data (cmd_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Commands waiting to be offered, and the results they are owed.
	cmd_item_t cmd_backlog[$];
	rsp_item_t rsp_owed[$];

	// Shadow copy of the axis state.
	logic signed [15:0] ax_pos, ax_lower, ax_upper, ax_target;
	bit                 ax_down, ax_run, ax_estop, ax_step;
	int unsigned        ax_pre_div, ax_pre_cnt, ax_top, ax_cnt, ax_speed;
	int unsigned        cur_move_speed;

	// Rate thresholds, prescaled clock rates and prescale factors.
	int unsigned floor_tab[20];
	int unsigned kclk_tab[20];
	int unsigned div_tab[20];

	// Run statistics and error count.
	int unsigned n_queued = 0, n_accepted = 0, n_checked = 0, n_errors = 0, n_cycles = 0;
	int unsigned n_steps = 0, n_mid_stops = 0, n_breaches = 0, n_rejects = 0, n_moves = 0;

	// Handshake pacing, set per phase.
	int unsigned gap_pct = 0, stall_pct = 0, hold_left = 0;
	bit          offer_taken = 1'b0;

	// Pick the prescale and period for a step rate and work out the rate achieved.
	task automatic ax_set_timing(input int unsigned rate);
		int unsigned i;
		int unsigned top;
		i = 0;
		while (i < 19 && rate <= floor_tab[i]) i++;
		if (rate == 0) begin
			top = 65535;
		end else begin
			top = kclk_tab[i] / rate - 1;
			if (top > 65535) top = 65535;
		end
		ax_pre_div = div_tab[i];
		ax_top = top;
		ax_speed = kclk_tab[i] / (top + 1);
		if (ax_speed > 65535) ax_speed = 65535;
	endtask

	task automatic ax_halt();
		ax_run = 1'b0;
		ax_speed = 0;
	endtask

	// Start a move; a target already reached in that direction leaves the axis halted.
	task automatic ax_start(input bit down, input logic signed [15:0] tgt, input int unsigned rate);
		ax_down = down;
		ax_target = tgt;
		ax_pre_cnt = 0;
		ax_cnt = 0;
		ax_step = 1'b0;
		ax_set_timing(rate);
		ax_run = 1'b1;
		if (down ? (ax_pos >= tgt) : (tgt >= ax_pos)) begin
			ax_halt();
		end else begin
			n_moves++;
		end
	endtask

	// Apply one command to the shadow state and form the result it yields.
	task automatic advance_axis(input cmd_item_t c, output rsp_item_t r);
		logic [1:0]  answer;
		int unsigned mid;
		answer = ST_OK;
		case (c.action)
			ACT_TICK: begin
				if (ax_run) begin
					ax_pre_cnt++;
					if (ax_pre_cnt >= ax_pre_div) begin
						ax_pre_cnt = 0;
						ax_cnt = (ax_cnt >= ax_top) ? 0 : ax_cnt + 1;
						mid = (ax_top + 1) / 2;
						// Mid-period: limit check first, then the stop request, then a step.
						if (ax_cnt == mid) begin
							if (ax_lower < ax_pos || ax_pos < ax_upper) begin
								ax_estop = 1'b1;
								ax_halt();
								n_breaches++;
							end else if (c.stop_request) begin
								ax_halt();
								n_mid_stops++;
							end else begin
								ax_step = 1'b1;
								n_steps++;
								if (ax_down) begin
									ax_pos = ax_pos + 16'sd1;
									if (ax_pos >= ax_target) ax_halt();
								end else begin
									ax_pos = ax_pos - 16'sd1;
									if (ax_target >= ax_pos) ax_halt();
								end
							end
						end
						if (ax_run && ax_cnt == ax_top) ax_step = 1'b0;
					end
				end
			end
			ACT_GO_TO: begin
				if (c.value < ax_lower && ax_upper < c.value) begin
					ax_start(ax_pos < c.value, c.value, cur_move_speed);
				end else begin
					answer = (c.value < ax_lower) ? ST_BEYOND_UPPER : ST_BEYOND_LOWER;
					n_rejects++;
				end
			end
			ACT_JOG: begin
				if (c.value == 0) ax_halt();
				else if (c.value < 0) ax_start(1'b0, ax_upper, -int'(c.value));
				else ax_start(1'b1, ax_lower, int'(c.value));
			end
			ACT_STOP:       ax_halt();
			ACT_ZERO:       ax_pos = '0;
			ACT_SET_UPPER:  ax_upper = c.value;
			ACT_SET_LOWER:  ax_lower = c.value;
			ACT_UPPER_HERE: ax_upper = ax_pos;
			ACT_LOWER_HERE: ax_lower = ax_pos;
			default: begin
			end
		endcase
		r.step_out      = ax_step;
		r.direction_out = ax_down;
		r.drive_enabled = ax_run;
		r.soft_estop    = ax_estop;
		r.position_out  = ax_pos;
		r.status        = answer;
		r.actual_speed  = ax_speed[15:0];
	endtask

	task automatic push_cmd(input logic [3:0] act, input logic [15:0] val, input logic stop);
		cmd_item_t c;
		c.action = act;
		c.value = val;
		c.stop_request = stop;
		cmd_backlog.push_back(c);
		n_queued++;
	endtask

	// Hold until every command has transferred and every result has come back.
	task automatic wait_idle();
		while (cmd_backlog.size() > 0 || rsp_owed.size() > 0) @(posedge clk);
	endtask

	// Write the go-to rate while the block is idle.
	task automatic write_move_speed(input logic [15:0] rate);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= rate;
		@(negedge clk);
		cfg_wen <= 1'b0;
		cur_move_speed = rate;
		@(posedge clk);
	endtask

	task automatic push_open_limits();
		push_cmd(ACT_SET_UPPER, 16'h8000, 1'($urandom));
		push_cmd(ACT_SET_LOWER, 16'h7FFF, 1'($urandom));
	endtask

	// Queue one random sequence: mostly moves followed by tick runs.
	task automatic queue_sequence();
		int unsigned        pick, stop_pct, n, cut;
		logic signed [15:0] v;
		pick = $urandom_range(99);
		if (pick < 60) begin
			// A move from a known spot, with an occasional interruption.
			if ($urandom_range(2) == 0) push_cmd(ACT_ZERO, 16'($urandom), 1'($urandom));
			if ($urandom_range(9) < 4) push_open_limits();
			if ($urandom_range(1) == 0) begin
				v = 16'($urandom_range(1, 3));
				if ($urandom_range(1) == 1) v = -v;
				if ($urandom_range(9) == 0) v = 16'($urandom);
				push_cmd(ACT_GO_TO, v, 1'($urandom));
			end else begin
				v = 16'($urandom_range(20000, 32767));
				if ($urandom_range(9) == 0) v = 16'($urandom);
				if ($urandom_range(1) == 1) v = -v;
				push_cmd(ACT_JOG, v, 1'($urandom));
			end
			pick = $urandom_range(9);
			stop_pct = (pick < 7) ? 0 : (pick < 9) ? 25 : 100;
			n = $urandom_range(300, 900);
			cut = ($urandom_range(3) == 0) ? $urandom_range(n - 1) : n;
			for (int i = 0; i < n; i++) begin
				if (i == cut) begin
					v = 16'($urandom_range(0, 8)) - 16'sd4;
					push_cmd(4'($urandom_range(int'(ACT_GO_TO), int'(ACT_LOWER_HERE))), v,
						1'($urandom));
				end
				push_cmd(ACT_TICK, 16'($urandom), $urandom_range(99) < stop_pct);
			end
		end else if (pick < 75) begin
			// Start with the count already outside one limit so the first step trips it.
			push_cmd(ACT_ZERO, 16'($urandom), 1'b0);
			if ($urandom_range(1) == 0) begin
				push_cmd(ACT_SET_UPPER, 16'h8000, 1'b0);
				push_cmd(ACT_SET_LOWER, -16'($urandom_range(1, 3)), 1'b0);
				push_cmd(ACT_JOG, -16'($urandom_range(25000, 32767)), 1'b0);
			end else begin
				push_cmd(ACT_SET_LOWER, 16'h7FFF, 1'b0);
				push_cmd(ACT_SET_UPPER, 16'($urandom_range(1, 3)), 1'b0);
				push_cmd(ACT_JOG, 16'($urandom_range(25000, 32767)), 1'b0);
			end
			n = $urandom_range(450, 700);
			for (int i = 0; i < n; i++) push_cmd(ACT_TICK, 16'($urandom), 1'b0);
			push_open_limits();
		end else if (pick < 88) begin
			// Limit changes, near the count or anywhere.
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				v = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 16)) - 16'sd8
					: 16'($urandom);
				push_cmd(4'($urandom_range(int'(ACT_SET_UPPER), int'(ACT_LOWER_HERE))), v,
					1'($urandom));
			end
		end else begin
			// Noise over every command code.
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++) push_cmd(4'($urandom), 16'($urandom), 1'($urandom));
		end
	endtask

	// Take the offered command on a transfer and predict its result.
	always @(posedge clk) begin : accept_cmd
		rsp_item_t want;
		cmd_item_t dropped;
		if (arst_n && cmd_valid && !cmd_stall) begin
			advance_axis(cmd_data, want);
			rsp_owed.push_back(want);
			dropped = cmd_backlog.pop_front();
			offer_taken = 1'b1;
			n_accepted++;
		end
	end

	// Offer the next command; an offered command holds until it transfers.
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || offer_taken) begin
			offer_taken = 1'b0;
			if (cmd_backlog.size() > 0 && $urandom_range(99) >= gap_pct) begin
				cmd_valid <= 1'b1;
				cmd_data <= cmd_backlog[0];
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: a long hold-off when one is requested, random otherwise.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each transferred result with the oldest one owed.
	always @(posedge clk) begin : check_rsp
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_owed.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("result with none owed: %h", rsp_data);
			end else begin
				want = rsp_owed.pop_front();
				n_checked++;
				if (rsp_data.step_out !== want.step_out
						|| rsp_data.direction_out !== want.direction_out
						|| rsp_data.drive_enabled !== want.drive_enabled
						|| rsp_data.soft_estop !== want.soft_estop
						|| rsp_data.position_out !== want.position_out
						|| rsp_data.status !== want.status
						|| rsp_data.actual_speed !== want.actual_speed) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("mismatch on result %0d: want step %b dir %b en %b estop %b pos %0d st %0d spd %0d",
							n_checked, want.step_out, want.direction_out, want.drive_enabled,
							want.soft_estop, want.position_out, want.status, want.actual_speed);
						$display("                      got  step %b dir %b en %b estop %b pos %0d st %0d spd %0d",
							rsp_data.step_out, rsp_data.direction_out, rsp_data.drive_enabled,
							rsp_data.soft_estop, rsp_data.position_out, rsp_data.status,
							rsp_data.actual_speed);
					end
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d results owed", n_cycles, rsp_owed.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Reset, directed commands, then paced random phases over several go-to rates.
	initial begin : stimulus
		int unsigned speeds[NUM_PHASES];
		int unsigned mode, first_item, first_mid;
		floor_tab = '{305, 152, 101, 76, 61, 50, 43, 38, 30, 25, 21, 19, 15, 12, 10, 9, 7, 6, 5, 0};
		kclk_tab = '{20000000, 10000000, 6666666, 5000000, 4000000, 3333333, 2857143, 2500000,
			2000000, 1666667, 1428571, 1250000, 1000000, 833333, 714286, 625000, 500000,
			416667, 357143, 312500};
		div_tab = '{1, 2, 3, 4, 5, 6, 7, 8, 10, 12, 14, 16, 20, 24, 28, 32, 40, 48, 56, 64};
		speeds = '{65535, 1, 40000, 305, 306, 65535, 5, 1};
		speeds[NUM_PHASES - 1] = $urandom_range(1, 65535);

		// Shadow state after reset.
		cur_move_speed = MOVE_SPEED_RESET;
		ax_pos = '0;
		ax_lower = 16'h7FFF;
		ax_upper = 16'h8000;
		ax_target = '0;
		ax_down = 1'b0;
		ax_run = 1'b0;
		ax_estop = 1'b0;
		ax_step = 1'b0;
		ax_pre_cnt = 0;
		ax_cnt = 0;
		ax_set_timing(cur_move_speed);
		ax_speed = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: refused and already-reached go-to, jog extremes, zero jog, limits.
		push_cmd(ACT_TICK, 16'hFFFF, 1'b1);
		push_cmd(ACT_GO_TO, 16'h7FFF, 1'b0);
		push_cmd(ACT_GO_TO, 16'h8000, 1'b0);
		push_cmd(ACT_GO_TO, 16'h0000, 1'b0);
		push_cmd(ACT_GO_TO, 16'h7FFE, 1'b1);
		push_cmd(ACT_TICK, 16'h0000, 1'b0);
		push_cmd(ACT_JOG, 16'h0000, 1'b0);
		push_cmd(ACT_JOG, 16'h8000, 1'b0);
		push_cmd(ACT_TICK, 16'h5555, 1'b1);
		push_cmd(ACT_STOP, 16'hAAAA, 1'b0);
		push_cmd(ACT_JOG, 16'h7FFF, 1'b0);
		push_cmd(ACT_JOG, 16'h0001, 1'b0);
		push_cmd(ACT_TICK, 16'h0000, 1'b0);
		push_cmd(ACT_JOG, 16'hFFFF, 1'b1);
		push_cmd(ACT_STOP, 16'h0000, 1'b1);
		push_cmd(ACT_ZERO, 16'h1234, 1'b1);
		push_cmd(ACT_SET_UPPER, 16'h7FFF, 1'b0);
		push_cmd(ACT_GO_TO, 16'h0005, 1'b0);
		push_cmd(ACT_SET_LOWER, 16'h8000, 1'b0);
		push_cmd(ACT_GO_TO, 16'h0000, 1'b0);
		push_cmd(ACT_UPPER_HERE, 16'hFFFF, 1'b1);
		push_cmd(ACT_LOWER_HERE, 16'h0000, 1'b0);
		push_cmd(ACT_JOG, 16'h0100, 1'b0);
		push_cmd(ACT_UNUSED_LO, 16'hFFFF, 1'b1);
		push_cmd(ACT_UNUSED_HI, 16'h8001, 1'b0);
		push_open_limits();
		wait_idle();

		// Random phases, each with its own pacing and go-to rate.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			mode = phase % 4;
			gap_pct = (mode == 1) ? 88 : (mode == 3) ? 32 : 0;
			stall_pct = (mode == 2) ? 88 : (mode == 3) ? 32 : 0;
			write_move_speed(16'(speeds[phase]));
			// One phase opens with the receiver holding off while commands keep coming.
			if (phase == 4) hold_left = HOLD_CYCLES;
			first_item = n_queued;
			first_mid = n_steps + n_mid_stops + n_breaches;
			while ((n_queued - first_item < 110 || n_steps + n_mid_stops + n_breaches - first_mid < 3)
					&& n_queued - first_item < 2500) begin
				queue_sequence();
				while (cmd_backlog.size() > 16) @(posedge clk);
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d commands, %0d results checked, %0d mismatches, %0d cycles",
			n_accepted, n_checked, n_errors, n_cycles);
		$display("%0d move starts, %0d steps, %0d stops at mid-period, %0d limit trips, %0d go-to refused",
			n_moves, n_steps, n_mid_stops, n_breaches, n_rejects);
		if (n_errors == 0 && rsp_owed.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
